[src/tnlv_pkg.sv]
// ----------------------------------------------------------------------------
// tnlv_pkg: shared types and constants for the lowest-value list
// Holds the slot entry, the per-cell control and status structs, the
// controller state encoding and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tnlv_pkg;

  localparam int ENERGY_W  = 32;
  localparam int RANK_W    = 6;
  localparam int OUT_POS_W = 16;

  localparam logic signed [ENERGY_W-1:0] EMPTY_LEVEL_RESET = 32'sd999999;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic                       valid;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic load;   // an item is accepted this cycle
    logic drop;   // the item equals slot 0 and is discarded
    logic drain;  // readout: every cell takes its successor's entry
  } cell_ctrl_t;

  // Compare results of one cell against the incoming energy.
  typedef struct packed {
    logic ge;     // stored energy >= incoming energy
    logic eq;     // stored energy == incoming energy
  } cell_status_t;

  typedef enum logic [0:0] {
    ST_COLLECT = 1'b0,
    ST_DRAIN   = 1'b1
  } state_t;

endpackage

`default_nettype wire

[src/tnlv_cell.sv]
// ----------------------------------------------------------------------------
// tnlv_cell: one slot of the sorted list
// Compares its entry with the incoming energy, then keeps it, takes the new
// value, takes its predecessor's entry, or during readout its successor's.
// ----------------------------------------------------------------------------
`default_nettype none

module tnlv_cell #(
  parameter int POSITION_BITS = 16
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire tnlv_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [tnlv_pkg::ENERGY_W-1:0] new_energy,
  input  wire [POSITION_BITS-1:0]                 new_pos,
  input  wire                                     prev_ge,
  input  wire tnlv_pkg::entry_t                   prev_entry,
  input  wire [POSITION_BITS-1:0]                 prev_pos,
  input  wire tnlv_pkg::entry_t                   next_entry,
  input  wire [POSITION_BITS-1:0]                 next_pos,
  output tnlv_pkg::cell_status_t                  status,
  output tnlv_pkg::entry_t                        entry,
  output logic [POSITION_BITS-1:0]                pos
);

  tnlv_pkg::entry_t           entry_r, entry_nxt;
  logic [POSITION_BITS-1:0]   pos_r, pos_nxt;

  always_comb begin
    status.ge = ($signed(entry_r.energy) >= $signed(new_energy));
    status.eq = (entry_r.energy == new_energy);
  end

  // The list is always sorted, so the insertion slot is the first cell whose
  // entry is not below the new value; every cell after it moves down one.
  always_comb begin
    entry_nxt = entry_r;
    pos_nxt   = pos_r;
    if (ctrl.drain) begin
      entry_nxt = next_entry;
      pos_nxt   = next_pos;
    end else if (ctrl.load && !ctrl.drop) begin
      if (status.ge && !prev_ge) begin
        entry_nxt.energy = new_energy;
        entry_nxt.valid  = 1'b1;
        pos_nxt          = new_pos;
      end else if (prev_ge) begin
        entry_nxt = prev_entry;
        pos_nxt   = prev_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.energy <= tnlv_pkg::EMPTY_LEVEL_RESET;
      entry_r.valid  <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  assign entry = entry_r;
  assign pos   = pos_r;

endmodule

`default_nettype wire

[src/top_n_lowest_values.sv]
// ----------------------------------------------------------------------------
// top_n_lowest_values: keeps the SLOTS smallest energies of a stream
// A row of compare-and-shift cells holds the list in ascending order, each
// entry tagged with its stream position; a marked last item starts readout.
// ----------------------------------------------------------------------------
// Usage. Energies arrive on the in_ channel (valid/ready) with a last-item
// flag. While collecting, one item is accepted every cycle: each cell compares
// its entry with the new energy in parallel and the list is updated in the
// same cycle. A value equal to the current smallest entry, or above every
// slot, is dropped, but it still takes a stream position. Positions count
// from zero and saturate at the top of their range.
// The item flagged last is inserted first; then in_ready falls and the list
// is read out on the out_ channel, one item per slot in rank order, the last
// one flagged by out_last_result. The first result is valid the cycle after
// the last item is accepted. Readout gives one result per slot, as the row
// shifts one entry toward the output per taken item; a stall simply holds
// the row. The slots shifted in behind are empty, so the list and position
// counter are clear when collection resumes.
// The cfg_ channel writes the empty level, always ready; a new level shows
// in the list at the next clear. Reset clears the list, the position counter
// and sets the empty level to 999999.
// ----------------------------------------------------------------------------
`default_nettype none

module top_n_lowest_values #(
  parameter int SLOTS         = 10,
  parameter int POSITION_BITS = 16
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // Input items
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire logic signed [tnlv_pkg::ENERGY_W-1:0]  in_energy,
  input  wire                                        in_last_item,
  // Result items
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic [tnlv_pkg::RANK_W-1:0]                out_rank,
  output logic signed [tnlv_pkg::ENERGY_W-1:0]       out_slot_energy_out,
  output logic [tnlv_pkg::OUT_POS_W-1:0]             out_position_out,
  output logic                                       out_filled,
  output logic                                       out_last_result,
  // Empty level register
  input  wire                                        cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic signed [tnlv_pkg::ENERGY_W-1:0]  cfg_empty_level
);

  localparam logic [tnlv_pkg::RANK_W-1:0] LAST_RANK = tnlv_pkg::RANK_W'(SLOTS - 1);

  tnlv_pkg::state_t                     state_r, state_nxt;
  logic [tnlv_pkg::RANK_W-1:0]          rank_r, rank_nxt;
  logic [POSITION_BITS-1:0]             pos_cnt_r, pos_cnt_nxt;
  logic signed [tnlv_pkg::ENERGY_W-1:0] empty_level_r;

  tnlv_pkg::cell_ctrl_t                 ctrl;
  tnlv_pkg::entry_t                     empty_entry;
  logic                                 in_fire, out_fire;

  tnlv_pkg::entry_t                     entry_w  [SLOTS];
  logic [POSITION_BITS-1:0]             pos_w    [SLOTS];
  tnlv_pkg::cell_status_t               status_w [SLOTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_level_r <= tnlv_pkg::EMPTY_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      empty_level_r <= cfg_empty_level;
    end
  end

  // Entry shifted into the tail during readout: this is what clears the list.
  always_comb begin
    empty_entry.energy = empty_level_r;
    empty_entry.valid  = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Controller: collect items, then drain the row one slot per taken result.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    rank_nxt   = rank_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.drain = 1'b0;
    // Equal to the smallest entry: the item is discarded.
    ctrl.drop  = status_w[0].eq;
    case (state_r)
      tnlv_pkg::ST_COLLECT: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
        rank_nxt  = '0;
        if (in_valid && in_last_item) begin
          state_nxt = tnlv_pkg::ST_DRAIN;
        end
      end
      tnlv_pkg::ST_DRAIN: begin
        out_valid  = 1'b1;
        ctrl.drain = out_ready;
        if (out_ready) begin
          rank_nxt = rank_r + 1'b1;
          if (rank_r == LAST_RANK) begin
            state_nxt = tnlv_pkg::ST_COLLECT;
            rank_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = tnlv_pkg::ST_COLLECT;
      end
    endcase
  end

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // The counter restarts after the last item because the list is cleared.
  always_comb begin
    pos_cnt_nxt = pos_cnt_r;
    if (in_fire) begin
      if (in_last_item) begin
        pos_cnt_nxt = '0;
      end else if (pos_cnt_r != '1) begin
        pos_cnt_nxt = pos_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tnlv_pkg::ST_COLLECT;
      rank_r    <= '0;
      pos_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rank_r    <= rank_nxt;
      pos_cnt_r <= pos_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Row of cells. Cell 0 holds the smallest energy and feeds the output.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tnlv_pkg::entry_t         prev_entry, next_entry;
    logic [POSITION_BITS-1:0] prev_pos, next_pos;
    logic                     prev_ge;

    if (g == 0) begin : g_head
      assign prev_entry = empty_entry;
      assign prev_pos   = '0;
      assign prev_ge    = 1'b0;
    end else begin : g_body
      assign prev_entry = entry_w[g-1];
      assign prev_pos   = pos_w[g-1];
      assign prev_ge    = status_w[g-1].ge;
    end

    if (g == SLOTS - 1) begin : g_tail
      assign next_entry = empty_entry;
      assign next_pos   = '0;
    end else begin : g_link
      assign next_entry = entry_w[g+1];
      assign next_pos   = pos_w[g+1];
    end

    tnlv_cell #(
      .POSITION_BITS (POSITION_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_energy (in_energy),
      .new_pos    (pos_cnt_r),
      .prev_ge    (prev_ge),
      .prev_entry (prev_entry),
      .prev_pos   (prev_pos),
      .next_entry (next_entry),
      .next_pos   (next_pos),
      .status     (status_w[g]),
      .entry      (entry_w[g]),
      .pos        (pos_w[g])
    );
  end

  // Results come straight from the head cell's registers and the rank count.
  assign out_rank            = rank_r;
  assign out_slot_energy_out = entry_w[0].energy;
  assign out_filled          = entry_w[0].valid;
  assign out_position_out    = entry_w[0].valid ? tnlv_pkg::OUT_POS_W'(pos_w[0]) : '0;
  assign out_last_result     = (rank_r == LAST_RANK);

`ifndef SYNTHESIS
  // Collection and readout never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while readout is active");

  // Readout starts at rank 0 right after the last item.
  a_readout_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_item) |=> (out_valid && (out_rank == '0)))
    else $error("readout did not start at rank 0");

  // Ranks step by one through the readout.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last_result) |=> (out_rank == $past(out_rank) + 1'b1))
    else $error("rank did not advance by one");

  // The list leaves in ascending order of energy.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last_result) |=>
      ($signed(out_slot_energy_out) >= $signed($past(out_slot_energy_out))))
    else $error("readout not in ascending order");
`endif

endmodule

`default_nettype wire

[sim/tb_top_n_lowest_values.sv]
// ----------------------------------------------------------------------------
// tb_top_n_lowest_values: self-checking bench for the lowest-value list
// Streams signed energies into the block and keeps its own copy of the
// ascending list, positions and counter. Every readout item is compared field
// by field with the slot it should carry. The empty level is changed between
// phases, and both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top_n_lowest_values;

  localparam int EW        = tnlv_pkg::ENERGY_W;
  localparam int RW        = tnlv_pkg::RANK_W;
  localparam int OPW       = tnlv_pkg::OUT_POS_W;
  localparam int SLOTS     = 10;
  localparam int POS_W     = 16;
  localparam int SET_BLOCK = 80;

  localparam logic [POS_W-1:0]     POS_MAX = '1;
  localparam logic signed [EW-1:0] E_MIN   = 32'h8000_0000;
  localparam logic signed [EW-1:0] E_MAX   = 32'h7FFF_FFFF;

  // One energy waiting to be sent, with its end-of-set flag.
  typedef struct packed {
    logic signed [EW-1:0] energy;
    logic                 last;
  } stim_t;

  // One slot as it should appear on the result channel.
  typedef struct packed {
    logic [RW-1:0]        rank;
    logic signed [EW-1:0] energy;
    logic [OPW-1:0]       pos;
    logic                 filled;
    logic                 last;
  } slot_rec_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic signed [EW-1:0] in_energy       = '0;
  logic                 in_last_item    = 1'b0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [RW-1:0]        out_rank;
  logic signed [EW-1:0] out_slot_energy_out;
  logic [OPW-1:0]       out_position_out;
  logic                 out_filled;
  logic                 out_last_result;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic signed [EW-1:0] cfg_empty_level = '0;

  top_n_lowest_values #(
    .SLOTS         (SLOTS),
    .POSITION_BITS (POS_W)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_energy           (in_energy),
    .in_last_item        (in_last_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rank            (out_rank),
    .out_slot_energy_out (out_slot_energy_out),
    .out_position_out    (out_position_out),
    .out_filled          (out_filled),
    .out_last_result     (out_last_result),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_empty_level     (cfg_empty_level)
  );

  always #5 clk = ~clk;

  // Energies waiting to go out, and slots waiting to be read back.
  stim_t     item_q[$];
  slot_rec_t readout_q[$];

  // Our copy of the list. The level is the one in force at the next clear.
  logic signed [EW-1:0] lst_energy [SLOTS];
  logic [POS_W-1:0]     lst_pos    [SLOTS];
  logic                 lst_filled [SLOTS];
  logic [POS_W-1:0]     stream_pos;
  logic signed [EW-1:0] level_now;

  int send_idle_pct = 27;
  int recv_idle_pct = 51;

  int n_queued       = 0;
  int n_items        = 0;
  int n_dropped      = 0;
  int n_readouts     = 0;
  int n_results      = 0;
  int n_level_writes = 0;
  int n_errors       = 0;

  stim_t     drv_item;
  slot_rec_t want;

  // A clear refills every slot with the level currently programmed and
  // restarts the stream position.
  function automatic void wipe_list();
    for (int k = 0; k < SLOTS; k++) begin
      lst_energy[k] = level_now;
      lst_pos[k]    = '0;
      lst_filled[k] = 1'b0;
    end
    stream_pos = '0;
  endfunction

  // Applies one accepted energy to the list. The value lands in front of the
  // first slot that is greater than or equal to it, except that a value equal
  // to slot 0 is discarded. A value above every slot finds no place at all.
  // When the set ends, the whole list is queued for readout and cleared.
  function automatic void take_energy(input logic signed [EW-1:0] e,
                                      input logic last);
    int        at;
    slot_rec_t r;
    at = -1;
    if (e < lst_energy[0]) begin
      at = 0;
    end else begin
      for (int k = 0; k < SLOTS - 1; k++) begin
        if (at < 0 && e > lst_energy[k] && e <= lst_energy[k+1]) begin
          at = k + 1;
        end
      end
    end
    if (at < 0) begin
      n_dropped++;
    end else begin
      for (int k = SLOTS - 1; k > at; k--) begin
        lst_energy[k] = lst_energy[k-1];
        lst_pos[k]    = lst_pos[k-1];
        lst_filled[k] = lst_filled[k-1];
      end
      lst_energy[at] = e;
      lst_pos[at]    = stream_pos;
      lst_filled[at] = 1'b1;
    end
    // Dropped values still use up a position; the count sticks at the top.
    if (stream_pos != POS_MAX) begin
      stream_pos = stream_pos + 1'b1;
    end
    if (last) begin
      for (int k = 0; k < SLOTS; k++) begin
        r.rank   = RW'(k);
        r.energy = lst_energy[k];
        r.pos    = lst_filled[k] ? OPW'(lst_pos[k]) : '0;
        r.filled = lst_filled[k];
        r.last   = (k == SLOTS - 1);
        readout_q.push_back(r);
      end
      n_readouts++;
      wipe_list();
    end
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic flag(input string msg);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Sender. A new item is offered only once the previous one has been taken,
  // so valid and the payload stay put while the block holds in_ready low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = item_q.pop_front();
        in_valid     <= 1'b1;
        in_energy    <= drv_item.energy;
        in_last_item <= drv_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Ready is redrawn every cycle, so stalls land anywhere in a
  // readout, including on its first and last slot.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor. Handshakes are judged on the values present just before the
  // edge, so the order of processes within the time step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        level_now = cfg_empty_level;
        n_level_writes++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (readout_q.size() == 0) begin
          flag($sformatf("rank %0d delivered with no readout outstanding", out_rank));
        end else begin
          want = readout_q.pop_front();
          if (out_rank !== want.rank)
            flag($sformatf("rank %0d, want %0d", out_rank, want.rank));
          if (out_slot_energy_out !== want.energy)
            flag($sformatf("rank %0d energy %0d, want %0d",
                           want.rank, out_slot_energy_out, want.energy));
          if (out_position_out !== want.pos)
            flag($sformatf("rank %0d position %0d, want %0d",
                           want.rank, out_position_out, want.pos));
          if (out_filled !== want.filled)
            flag($sformatf("rank %0d filled %b, want %b",
                           want.rank, out_filled, want.filled));
          if (out_last_result !== want.last)
            flag($sformatf("rank %0d last flag %b, want %b",
                           want.rank, out_last_result, want.last));
        end
      end
      if (in_valid && in_ready) begin
        take_energy(in_energy, in_last_item);
        n_items++;
      end
    end
  end

  task automatic push_item(input logic signed [EW-1:0] e, input logic last);
    stim_t s;
    s.energy = e;
    s.last   = last;
    item_q.push_back(s);
    n_queued++;
  endtask

  // Waits until every queued item is in and every readout is out. A set may
  // still be open, so the task then waits on to let the row finish its last update.
  task automatic wait_idle();
    while (n_items != n_queued || readout_q.size() != 0) @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);
  endtask

  task automatic write_level(input logic signed [EW-1:0] v);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_empty_level <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random sets of random length. Energies mix full-range values, tight
  // clusters that produce ties with slot 0, values around the empty level,
  // the signed extremes and short falling runs. A set cut off by the end of
  // the block stays open across the next level change.
  task automatic gen_block(input int n, input logic signed [EW-1:0] level);
    int                   made;
    int                   len;
    logic signed [EW-1:0] base;
    logic signed [EW-1:0] e;
    made = 0;
    while (made < n) begin
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 12);
      base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40) - 20;
      e    = base;
      for (int i = 0; i < len && made < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: e = $urandom;
          4, 5, 6:    e = base + $urandom_range(0, 6) - 3;
          7:          e = level + $urandom_range(0, 4) - 2;
          8: begin
            case ($urandom_range(0, 3))
              0:       e = E_MIN;
              1:       e = E_MAX;
              2:       e = '0;
              default: e = '1;
            endcase
          end
          default:    e = e - $urandom_range(0, 3);
        endcase
        push_item(e, i == len - 1);
        made++;
      end
    end
  endtask

  logic signed [EW-1:0] level_plan [6];

  initial begin
    level_now = tnlv_pkg::EMPTY_LEVEL_RESET;
    wipe_list();
    // Extremes first, then zero, a random level, the reset value and a
    // slightly negative one.
    level_plan[0] = E_MAX;
    level_plan[1] = E_MIN;
    level_plan[2] = '0;
    level_plan[3] = $urandom;
    level_plan[4] = tnlv_pkg::EMPTY_LEVEL_RESET;
    level_plan[5] = -5;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets at the reset level. A repeat of the smallest value is
    // dropped, a value equal to the empty level slips in behind the real
    // entries, values above the level and the largest energy are dropped,
    // and a tie with a later slot goes in front of it.
    push_item(5, 1'b0);
    push_item(5, 1'b0);
    push_item(tnlv_pkg::EMPTY_LEVEL_RESET, 1'b0);
    push_item(tnlv_pkg::EMPTY_LEVEL_RESET + 1, 1'b0);
    push_item(E_MIN, 1'b0);
    push_item(E_MAX, 1'b0);
    push_item(7, 1'b0);
    push_item(7, 1'b0);
    push_item(-1, 1'b1);
    // On an empty list the empty level itself ties with slot 0 and is
    // dropped, even as the last item: the readout shows only empty slots.
    push_item(tnlv_pkg::EMPTY_LEVEL_RESET, 1'b1);
    // Twelve falling values overrun the list, so the oldest fall off the end.
    for (int i = 0; i < 12; i++) push_item(100 - i, i == 11);
    wait_idle();

    // Random part: two blocks per stall pattern, each under its own level.
    for (int b = 0; b < 6; b++) begin
      if (b < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 51;
      end else if (b < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_level(level_plan[b]);
      gen_block(SET_BLOCK, level_plan[b]);
      wait_idle();
    end

    // A closing item reads out whatever set the last block left open.
    push_item(0, 1'b1);
    wait_idle();

    if (readout_q.size() != 0) begin
      flag($sformatf("%0d slots never read out", readout_q.size()));
    end
    $display("Covered %0d items in %0d readouts, %0d slots checked, %0d values dropped.",
             n_items, n_readouts, n_results, n_dropped);
    $display("Empty level written %0d times, including both signed extremes.",
             n_level_writes);
    if (n_errors == 0) begin
      $display("tb_top_n_lowest_values OK");
    end else begin
      $display("tb_top_n_lowest_values NOT OK");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, even if every item closed
  // a set and both channels stalled heavily.
  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d items in, %0d slots outstanding.",
             n_items, n_queued, readout_q.size());
    $display("tb_top_n_lowest_values NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[top_n_lowest_values.f]
src/tnlv_pkg.sv
src/tnlv_cell.sv
src/top_n_lowest_values.sv
sim/tb_top_n_lowest_values.sv
